/* design/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
package deq_pkg;

   // Request action codes; codes six and seven are unused and ignored.
   typedef enum logic [2:0] {
      ACT_INS_FRONT  = 3'd0,
      ACT_INS_BACK   = 3'd1,
      ACT_REM_FRONT  = 3'd2,
      ACT_REM_BACK   = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 8;

   // Memory strobes from the pointer logic.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_type;

   // Result info that travels alongside the store read.
   typedef struct packed {
      logic               is_read;
      status_type         status;
      logic [OCC_W-1:0]   occupancy;
   } info_type;

endpackage

/* design/deq_ram.sv */
// Generic simple dual-port RAM with registered read.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/deq_ctrl.sv */
// Head pointer and count registers, ring address and status for each request.
module deq_ctrl #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  deq_pkg::action_type      action,
   output logic [$clog2(DEPTH)-1:0] addr,
   output deq_pkg::mem_type         mem,
   output deq_pkg::info_type        info
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic          full;
   logic          empty;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] back_off;
   logic [AW:0]   back_sum;
   logic [AW-1:0] back_pos;
   logic          wr;
   logic          rd;
   deq_pkg::status_type status;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : AW'(head_ff - AW'(1));
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : AW'(head_ff + AW'(1));

   // back insert goes to head+count, back read to head+count-1
   assign back_off = (action == deq_pkg::ACT_INS_BACK) ? AW'(count_ff)
                                                      : AW'(count_ff - CW'(1));
   assign back_sum = (AW+1)'(head_ff) + (AW+1)'(back_off);
   assign back_pos = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                  : AW'(back_sum);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      addr     = head_ff;
      wr       = 1'b0;
      rd       = 1'b0;
      status   = deq_pkg::STAT_OK;
      case (action)
         deq_pkg::ACT_INS_FRONT: begin
            if (full) begin
               status = deq_pkg::STAT_FULL;
            end else begin
               addr     = head_dec;
               wr       = 1'b1;
               head_in  = head_dec;
               count_in = CW'(count_ff + CW'(1));
            end
         end
         deq_pkg::ACT_INS_BACK: begin
            if (full) begin
               status = deq_pkg::STAT_FULL;
            end else begin
               addr     = back_pos;
               wr       = 1'b1;
               count_in = CW'(count_ff + CW'(1));
            end
         end
         deq_pkg::ACT_REM_FRONT: begin
            if (empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               rd       = 1'b1;
               head_in  = head_inc;
               count_in = CW'(count_ff - CW'(1));
            end
         end
         deq_pkg::ACT_REM_BACK: begin
            if (empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               addr     = back_pos;
               rd       = 1'b1;
               count_in = CW'(count_ff - CW'(1));
            end
         end
         deq_pkg::ACT_PEEK_FRONT: begin
            if (empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               rd = 1'b1;
            end
         end
         deq_pkg::ACT_PEEK_BACK: begin
            if (empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               addr = back_pos;
               rd   = 1'b1;
            end
         end
         default: begin
            // unused codes leave everything as it is
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign mem.wr_en      = accept & wr;
   assign mem.rd_en      = accept & rd;
   assign info.is_read   = rd;
   assign info.status    = status;
   assign info.occupancy = deq_pkg::OCC_W'(count_in);

endmodule

/* design/double_ended_queue.sv */
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//   channel | dir | tdata fields (low bit up)                     | beat
//   req_    | in  | action[2:0], value[34:3], zero pad to 40 bits | one request
//   rsp_    | out | word[31:0], status[33:32], occupancy[41:34]   | one result
//
// Flow: one request per cycle while rsp_ is not stalled; a result passes the ring
//   read register, then the output register, before it shows on rsp_.
// Each request touches at most one entry of the single ring RAM; a write lands at
//   its edge, so the next request reading that entry sees it, no bypass.
// Reset clears head, count and the pipe valids; the ring has no reset and
//   needs no clearing pass, every read is guarded by the count.
// A stalled rsp_ holds the output register and the pending RAM read; req_
//   is refused only while both are full.
module double_ended_queue #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action[2:0], value[34:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // word[31:0], status[33:32], occupancy[41:34]
);

   localparam int AW = $clog2(DEPTH);

   logic                       req_accept;
   logic                       s1_move;
   deq_pkg::action_type        action;
   logic [deq_pkg::WORD_W-1:0] value;

   logic [AW-1:0]              addr;
   deq_pkg::mem_type           mem;
   deq_pkg::info_type          info;
   logic [deq_pkg::WORD_W-1:0] rd_data;

   // stage 1: RAM read in flight
   logic                       s1_valid_ff, s1_valid_in;
   deq_pkg::info_type          s1_info_ff, s1_info_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [deq_pkg::WORD_W-1:0] out_word_ff, out_word_in;
   deq_pkg::status_type        out_status_ff, out_status_in;
   logic [deq_pkg::OCC_W-1:0]  out_occ_ff, out_occ_in;

   assign action = deq_pkg::action_type'(req_tdata[2:0]);
   assign value  = req_tdata[34:3];

   assign s1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   deq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .action (action),
      .addr   (addr),
      .mem    (mem),
      .info   (info)
   );

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (addr),
      .wr_data (value),
      .rd_en   (mem.rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_info_in  = s1_info_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_info_in  = info;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      out_status_in = out_status_ff;
      out_occ_in    = out_occ_ff;
      if (s1_move) begin
         out_valid_in  = s1_valid_ff;
         // word is zero for inserts, errors and unused codes
         out_word_in   = s1_info_ff.is_read ? rd_data : '0;
         out_status_in = s1_info_ff.status;
         out_occ_in    = s1_info_ff.occupancy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff    <= s1_info_in;
      out_word_ff   <= out_word_in;
      out_status_ff <= out_status_in;
      out_occ_ff    <= out_occ_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_occ_ff, out_status_ff, out_word_ff};

   // write and read never go out in the same cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem.wr_en && mem.rd_en))
      else $error("ring write and read issued together");

   // a store access only happens for a request that succeeds
   a_access_ok: assert property (@(posedge clock) disable iff (reset)
      (mem.wr_en || mem.rd_en) |-> (req_accept && info.status == deq_pkg::STAT_OK))
      else $error("ring access for refused request");

   // a pending read only ever belongs to a good request
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_info_ff.is_read) |-> (s1_info_ff.status == deq_pkg::STAT_OK))
      else $error("read flagged with error status");

   // both stages full and output stalled: no new request may enter
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipe is blocked");

   // a stalled read keeps its RAM data
   a_hold_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> $stable(rd_data))
      else $error("pending read data changed during stall");

endmodule
